### hw/rtl/lpffs_pkg.sv
// ----------------------------------------------------------------------------
// lpffs_pkg
// Sizes, codes and types shared by the LED panel fade frame sender.
// ----------------------------------------------------------------------------
`default_nettype none

package lpffs_pkg;

   // Chain and table geometry
   localparam int GRADIENT_ENTRIES = 128;
   localparam int MODULES          = 20;
   localparam int LEDS_PER_MODULE  = 8;

   // Table address width and the upper bounce point of the window offset
   localparam int ENTRY_AW     = $clog2(GRADIENT_ENTRIES);
   localparam int WINDOW_LIMIT = (GRADIENT_ENTRIES > MODULES) ?
                                 (GRADIENT_ENTRIES - MODULES) : 0;
   localparam int OFFSET_W     = ENTRY_AW;

   // Counter widths
   localparam int MOD_CNT_W = (MODULES > 1) ? $clog2(MODULES) : 1;
   localparam int LED_CNT_W = (LEDS_PER_MODULE > 1) ? $clog2(LEDS_PER_MODULE) : 1;

   // Width of module plus offset, wide enough to see a read beyond the table
   localparam int IDX_W = ((OFFSET_W > MOD_CNT_W) ? OFFSET_W : MOD_CNT_W) + 1;

   // Payload field widths
   localparam int ENTRY_INDEX_W = 7;
   localparam int COLOR_W       = 8;
   localparam int ENTRY_W       = 4 * COLOR_W;
   localparam int MODULE_NUM_W  = 5;
   localparam int LED_NUM_W     = 3;
   localparam int REQ_TDATA_W   = 40;
   localparam int RSP_TDATA_W   = 16;

   typedef enum logic [1:0] {
      FUNC_TICK  = 2'd0,
      FUNC_READY = 2'd1,
      FUNC_WRITE = 2'd2
   } func_type;

   typedef enum logic [1:0] {
      CH_GREEN = 2'd0,
      CH_RED   = 2'd1,
      CH_BLUE  = 2'd2,
      CH_WHITE = 2'd3
   } channel_type;

   // Byte in flight while the table read completes
   typedef struct packed {
      channel_type              channel;
      logic [MODULE_NUM_W-1:0]  module_number;
      logic [LED_NUM_W-1:0]     led_number;
      logic                     last_of_frame;
      logic                     in_range;
   } read_stage_type;

endpackage : lpffs_pkg

`default_nettype wire

### hw/rtl/lpffs_ram.sv
// ----------------------------------------------------------------------------
// lpffs_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that updates only when read enable is high.
// ----------------------------------------------------------------------------
`default_nettype none

module lpffs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire [$clog2(DEPTH)-1:0]  wr_addr,
   input  wire [WIDTH-1:0]          wr_data,
   input  wire                      rd_en,
   input  wire [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule : lpffs_ram

`default_nettype wire

### hw/rtl/led_panel_fade_frame_sender.sv
// ----------------------------------------------------------------------------
// led_panel_fade_frame_sender
// Streams RGBW colour bytes to a chain of LED modules from a gradient table.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one transaction per command, func in req_tuser: a table
//   write stores four colour bytes, a timer tick (ignored while a frame is
//   open) bounces the window offset and opens a frame, and a ready asks for
//   the next byte. Every LED of module m shows table entry m + offset.
//   Bytes leave on rsp_* in the order green, red, blue, white per LED,
//   tlast marking the final byte. The ready after the final byte closes the
//   frame and produces no transaction.
// Pipeline and throughput:
//   One command per cycle while req_tready is high. A byte goes from its
//   command into the read stage, which holds the synchronous table read, and
//   then into the output register on rsp_*. The counters and offset live in
//   flops, so a command can follow in the next cycle.
// Reset and stall:
//   Reset clears counters, offset, frame state and both pipeline valids; the
//   table holds garbage until written. When rsp_tready is low the output
//   register holds; a second byte waits behind it in the read stage, and only
//   when both are full does req_tready drop.
// ----------------------------------------------------------------------------
`default_nettype none

module led_panel_fade_frame_sender (
   input  wire         clock,
   input  wire         reset,
   // command channel
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [39:0] req_tdata,  // entry_index[6:0], entry_green[14:7], entry_red[22:15],
                                   // entry_blue[30:23], entry_white[38:31], zero pad[39]
   input  wire  [1:0]  req_tuser,  // func[1:0]
   // byte channel
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [15:0] rsp_tdata,  // color_byte[7:0], module_number[12:8], led_number[15:13]
   output logic [1:0]  rsp_tuser,  // channel[1:0]
   output logic        rsp_tlast   // last_of_frame
);

   localparam int AW = lpffs_pkg::ENTRY_AW;
   localparam int OW = lpffs_pkg::OFFSET_W;
   localparam int MW = lpffs_pkg::MOD_CNT_W;
   localparam int LW = lpffs_pkg::LED_CNT_W;
   localparam int XW = lpffs_pkg::IDX_W;
   localparam int CW = lpffs_pkg::COLOR_W;

   // Frame and window state
   logic [OW-1:0]            window_offset_ff, window_offset_in;
   logic                     offset_rising_ff, offset_rising_in;
   lpffs_pkg::channel_type   next_channel_ff, next_channel_in;
   logic [LW-1:0]            led_counter_ff, led_counter_in;
   logic [MW-1:0]            module_counter_ff, module_counter_in;
   logic                     frame_bytes_done_ff, frame_bytes_done_in;
   logic                     frame_active_ff, frame_active_in;

   // Read stage and output register
   logic                       s1_valid_ff, s1_valid_in;
   lpffs_pkg::read_stage_type  s1_ff, s1_in;
   logic                       out_valid_ff, out_valid_in;
   logic [CW-1:0]              out_color_ff;
   logic [1:0]                 out_channel_ff;
   logic [lpffs_pkg::MODULE_NUM_W-1:0] out_module_ff;
   logic [lpffs_pkg::LED_NUM_W-1:0]    out_led_ff;
   logic                       out_last_ff;

   // Command fields
   lpffs_pkg::func_type             func;
   logic [lpffs_pkg::ENTRY_INDEX_W-1:0] entry_index;
   logic [lpffs_pkg::ENTRY_W-1:0]   entry_word;

   logic              accept;
   logic              advance;
   logic              do_send;
   logic              emit;
   logic              wr_en;
   logic [XW-1:0]     rd_idx;
   logic [OW:0]       offset_inc;
   logic [OW-1:0]     offset_dec;
   logic [lpffs_pkg::ENTRY_W-1:0] rd_data;
   logic [CW-1:0]     sel_color;

   assign func        = lpffs_pkg::func_type'(req_tuser);
   assign entry_index = req_tdata[6:0];
   // table word: green low byte up to white high byte
   assign entry_word  = {req_tdata[38:31], req_tdata[30:23], req_tdata[22:15], req_tdata[14:7]};

   // Stall only when the read stage holds a byte that cannot move on
   assign advance    = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !(s1_valid_ff && !advance);
   assign accept     = req_tvalid && req_tready;

   assign offset_inc = {1'b0, window_offset_ff} + {{OW{1'b0}}, 1'b1};
   assign offset_dec = (window_offset_ff != '0) ? (window_offset_ff - 1'b1) : window_offset_ff;

   // Table address from the offset this command leaves behind
   assign rd_idx = XW'(module_counter_ff) + XW'(window_offset_in);

   always_comb begin
      window_offset_in    = window_offset_ff;
      offset_rising_in    = offset_rising_ff;
      next_channel_in     = next_channel_ff;
      led_counter_in      = led_counter_ff;
      module_counter_in   = module_counter_ff;
      frame_bytes_done_in = frame_bytes_done_ff;
      frame_active_in     = frame_active_ff;
      do_send             = 1'b0;
      emit                = 1'b0;
      wr_en               = 1'b0;
      s1_in               = s1_ff;

      if (accept) begin
         case (func)
            lpffs_pkg::FUNC_TICK: begin
               // bounce the window, then open a frame
               if (!frame_active_ff) begin
                  if (offset_rising_ff) begin
                     window_offset_in = offset_inc[OW-1:0];
                     if (offset_inc >= (OW+1)'(lpffs_pkg::WINDOW_LIMIT)) begin
                        offset_rising_in = 1'b0;
                     end
                  end else begin
                     window_offset_in = offset_dec;
                     if (offset_dec == '0) begin
                        offset_rising_in = 1'b1;
                     end
                  end
                  do_send = 1'b1;
               end
            end
            lpffs_pkg::FUNC_READY: begin
               do_send = 1'b1;
            end
            lpffs_pkg::FUNC_WRITE: begin
               wr_en = (32'(entry_index) < 32'(lpffs_pkg::GRADIENT_ENTRIES));
            end
            default: begin
            end
         endcase
      end

      if (do_send) begin
         frame_active_in = 1'b1;
         if (frame_bytes_done_ff) begin
            // close the frame, no byte
            frame_bytes_done_in = 1'b0;
            frame_active_in     = 1'b0;
         end else begin
            emit                = 1'b1;
            s1_in.channel       = next_channel_ff;
            s1_in.module_number = lpffs_pkg::MODULE_NUM_W'(module_counter_ff);
            s1_in.led_number    = lpffs_pkg::LED_NUM_W'(led_counter_ff);
            s1_in.last_of_frame = 1'b0;
            s1_in.in_range      = (32'(rd_idx) < 32'(lpffs_pkg::GRADIENT_ENTRIES));
            next_channel_in     = lpffs_pkg::channel_type'(next_channel_ff + 2'd1);
            if (next_channel_ff == lpffs_pkg::CH_WHITE) begin
               if (led_counter_ff >= LW'(lpffs_pkg::LEDS_PER_MODULE - 1)) begin
                  led_counter_in = '0;
                  if (module_counter_ff < MW'(lpffs_pkg::MODULES - 1)) begin
                     module_counter_in = module_counter_ff + 1'b1;
                  end else begin
                     module_counter_in   = '0;
                     frame_bytes_done_in = 1'b1;
                     s1_in.last_of_frame = 1'b1;
                  end
               end else begin
                  led_counter_in = led_counter_ff + 1'b1;
               end
            end
         end
      end
   end

   // Gradient table
   lpffs_ram #(
      .WIDTH (lpffs_pkg::ENTRY_W),
      .DEPTH (lpffs_pkg::GRADIENT_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(entry_index)),
      .wr_data (entry_word),
      .rd_en   (emit),
      .rd_addr (rd_idx[AW-1:0]),
      .rd_data (rd_data)
   );

   // Pick the byte of this channel; a read beyond the table gives zero
   assign sel_color = s1_ff.in_range ? rd_data[{s1_ff.channel, 3'b000} +: CW] : '0;

   always_comb begin
      s1_valid_in  = emit ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
      out_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_offset_ff    <= '0;
         offset_rising_ff    <= 1'b1;
         next_channel_ff     <= lpffs_pkg::CH_GREEN;
         led_counter_ff      <= '0;
         module_counter_ff   <= '0;
         frame_bytes_done_ff <= 1'b0;
         frame_active_ff     <= 1'b0;
         s1_valid_ff         <= 1'b0;
         out_valid_ff        <= 1'b0;
      end else begin
         window_offset_ff    <= window_offset_in;
         offset_rising_ff    <= offset_rising_in;
         next_channel_ff     <= next_channel_in;
         led_counter_ff      <= led_counter_in;
         module_counter_ff   <= module_counter_in;
         frame_bytes_done_ff <= frame_bytes_done_in;
         frame_active_ff     <= frame_active_in;
         s1_valid_ff         <= s1_valid_in;
         out_valid_ff        <= out_valid_in;
      end
   end

   // Payload: load the read stage on a new byte, the output on advance
   always_ff @(posedge clock) begin
      if (emit) begin
         s1_ff <= s1_in;
      end
      if (advance) begin
         out_color_ff   <= sel_color;
         out_channel_ff <= s1_ff.channel;
         out_module_ff  <= s1_ff.module_number;
         out_led_ff     <= s1_ff.led_number;
         out_last_ff    <= s1_ff.last_of_frame;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_led_ff, out_module_ff, out_color_ff};
   assign rsp_tuser  = out_channel_ff;
   assign rsp_tlast  = out_last_ff;

   // A blocked read stage must not take a new command
   a_no_accept_when_full: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && out_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("command accepted while read stage blocked");

   // A blocked byte stays in the read stage
   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && out_valid_ff && !rsp_tready) |=> s1_valid_ff)
      else $error("read stage byte lost under stall");

   // Once all bytes are sent the counters are back at their start
   a_done_counters: assert property (@(posedge clock) disable iff (reset)
      frame_bytes_done_ff |-> (frame_active_ff && module_counter_ff == '0 &&
                               led_counter_ff == '0 &&
                               next_channel_ff == lpffs_pkg::CH_GREEN))
      else $error("frame done with counters not cleared");

   // The last byte is the white byte of the final LED of the final module
   a_last_position: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |->
         (rsp_tuser == lpffs_pkg::CH_WHITE &&
          rsp_tdata[12:8] == lpffs_pkg::MODULE_NUM_W'(lpffs_pkg::MODULES - 1) &&
          rsp_tdata[15:13] == lpffs_pkg::LED_NUM_W'(lpffs_pkg::LEDS_PER_MODULE - 1)))
      else $error("last byte at wrong position");

   // The window never leaves its bounce range
   a_offset_range: assert property (@(posedge clock) disable iff (reset)
      (32'(window_offset_ff) <= 32'(lpffs_pkg::WINDOW_LIMIT) ||
       window_offset_ff == OW'(1)))
      else $error("window offset out of range");

endmodule : led_panel_fade_frame_sender

`default_nettype wire

### bench/led_panel_fade_frame_sender_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_panel_fade_frame_sender_test
// Self-checking bench for the fade frame sender: drives table writes, ticks
// and ready commands, predicts every colour byte of each frame and checks
// the byte stream field by field under random stalls on both channels.
// ----------------------------------------------------------------------------

module led_panel_fade_frame_sender_test;

   // Local copies of the shared sizes
   localparam int GRADIENT_ENTRIES = lpffs_pkg::GRADIENT_ENTRIES;
   localparam int MODULES          = lpffs_pkg::MODULES;
   localparam int LEDS_PER_MODULE  = lpffs_pkg::LEDS_PER_MODULE;
   localparam int WINDOW_LIMIT     = lpffs_pkg::WINDOW_LIMIT;
   localparam int OFFSET_W         = lpffs_pkg::OFFSET_W;
   localparam int MOD_CNT_W        = lpffs_pkg::MOD_CNT_W;
   localparam int LED_CNT_W        = lpffs_pkg::LED_CNT_W;
   localparam int ENTRY_INDEX_W    = lpffs_pkg::ENTRY_INDEX_W;
   localparam int COLOR_W          = lpffs_pkg::COLOR_W;
   localparam int ENTRY_W          = lpffs_pkg::ENTRY_W;
   localparam int MODULE_NUM_W     = lpffs_pkg::MODULE_NUM_W;
   localparam int LED_NUM_W        = lpffs_pkg::LED_NUM_W;
   localparam int REQ_TDATA_W      = lpffs_pkg::REQ_TDATA_W;
   localparam int RSP_TDATA_W      = lpffs_pkg::RSP_TDATA_W;

   // Unused command code, must be ignored by the block
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   // Length of the forced output stall and of the final settle window
   localparam int LONG_HOLD_CYCLES = 200;
   localparam int SETTLE_CYCLES    = 16;
   localparam int DRAIN_CAP        = 20000;

   // One colour byte as seen on the byte channel
   typedef struct {
      logic [COLOR_W-1:0]      color;
      lpffs_pkg::channel_type  ch;
      logic [MODULE_NUM_W-1:0] module_no;
      logic [LED_NUM_W-1:0]    led_no;
      logic                    last;
   } led_byte_type;

   // Tracks the gradient table, window offset and frame counters, and holds
   // the colour bytes still owed by the block.
   class fade_frame_scoreboard;
      logic [ENTRY_W-1:0]     gradient [GRADIENT_ENTRIES];
      logic [OFFSET_W-1:0]    offset;
      logic                   rising;
      lpffs_pkg::channel_type next_ch;
      logic [LED_CNT_W-1:0]   led_cnt;
      logic [MOD_CNT_W-1:0]   mod_cnt;
      logic                   bytes_done;
      logic                   frame_open;
      led_byte_type           owed_bytes [$];
      int                     errors;
      int                     bytes_checked;
      int                     frames_closed;
      int                     offset_peak;

      function new();
         offset     = '0;
         rising     = 1'b1;
         next_ch    = lpffs_pkg::CH_GREEN;
         led_cnt    = '0;
         mod_cnt    = '0;
         bytes_done = 1'b0;
         frame_open = 1'b0;
      endfunction

      function int pending();
         return owed_bytes.size();
      endfunction

      // Bounce the window between zero and the upper limit
      function void move_window();
         if (rising) begin
            offset = offset + 1'b1;
            if (offset >= WINDOW_LIMIT) rising = 1'b0;
         end else begin
            if (offset > 0) offset = offset - 1'b1;
            if (offset == 0) rising = 1'b1;
         end
         if (offset > offset_peak) offset_peak = offset;
      endfunction

      // Advance one byte of the frame, or close it after the final byte
      function void advance_frame();
         led_byte_type       b;
         int                 idx;
         logic [ENTRY_W-1:0] entry;
         logic [1:0]         nc;
         frame_open = 1'b1;
         if (bytes_done) begin
            bytes_done = 1'b0;
            frame_open = 1'b0;
            frames_closed++;
            return;
         end
         idx       = int'(mod_cnt) + int'(offset);
         entry     = (idx < GRADIENT_ENTRIES) ? gradient[idx] : '0;
         b.color   = entry[COLOR_W * int'(next_ch) +: COLOR_W];
         b.ch      = next_ch;
         b.module_no = mod_cnt;
         b.led_no  = led_cnt;
         b.last    = 1'b0;
         nc        = next_ch + 2'd1;
         next_ch   = lpffs_pkg::channel_type'(nc);
         if (next_ch == lpffs_pkg::CH_GREEN) begin
            if (led_cnt >= LEDS_PER_MODULE - 1) begin
               led_cnt = '0;
               if (mod_cnt < MODULES - 1) begin
                  mod_cnt = mod_cnt + 1'b1;
               end else begin
                  mod_cnt    = '0;
                  bytes_done = 1'b1;
                  b.last     = 1'b1;
               end
            end else begin
               led_cnt = led_cnt + 1'b1;
            end
         end
         owed_bytes.push_back(b);
      endfunction

      // Update the prediction for one accepted command
      function void note_command(logic [1:0] code, logic [ENTRY_INDEX_W-1:0] index,
                                 logic [ENTRY_W-1:0] entry);
         case (code)
            lpffs_pkg::FUNC_TICK: begin
               if (!frame_open) begin
                  move_window();
                  advance_frame();
               end
            end
            lpffs_pkg::FUNC_READY: advance_frame();
            lpffs_pkg::FUNC_WRITE: begin
               if (index < GRADIENT_ENTRIES) gradient[index] = entry;
            end
            default: ;
         endcase
      endfunction

      // Compare one accepted byte with the oldest owed byte
      function void check_byte(logic [COLOR_W-1:0] color, logic [1:0] ch,
                               logic [MODULE_NUM_W-1:0] module_no,
                               logic [LED_NUM_W-1:0] led_no, logic last);
         led_byte_type e;
         if (owed_bytes.size() == 0) begin
            errors++;
            $display("%0t: byte with nothing owed: expected none actual color %02h ch %0d",
                     $time, color, ch);
            return;
         end
         e = owed_bytes.pop_front();
         bytes_checked++;
         if (color !== e.color) begin
            errors++;
            $display("%0t: color_byte mismatch: expected %02h actual %02h",
                     $time, e.color, color);
         end
         if (ch !== e.ch) begin
            errors++;
            $display("%0t: channel mismatch: expected %0d actual %0d", $time, e.ch, ch);
         end
         if (module_no !== e.module_no) begin
            errors++;
            $display("%0t: module_number mismatch: expected %0d actual %0d",
                     $time, e.module_no, module_no);
         end
         if (led_no !== e.led_no) begin
            errors++;
            $display("%0t: led_number mismatch: expected %0d actual %0d",
                     $time, e.led_no, led_no);
         end
         if (last !== e.last) begin
            errors++;
            $display("%0t: last_of_frame mismatch: expected %0d actual %0d",
                     $time, e.last, last);
         end
      endfunction
   endclass

   // Clock, reset and block inputs, all known from time zero
   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [1:0]             req_tuser  = '0;
   logic                   rsp_tready = 1'b0;

   wire                    req_tready;
   wire                    rsp_tvalid;
   wire  [RSP_TDATA_W-1:0] rsp_tdata;
   wire  [1:0]             rsp_tuser;
   wire                    rsp_tlast;

   // Idle rates in percent, changed between phases by the stimulus
   int send_idle_pct = 16;
   int recv_idle_pct = 78;

   // Long output stall: the stimulus raises the request, the receiver counts
   logic long_hold_request = 1'b0;
   bit   hold_taken = 1'b0;
   int   hold_left = 0;
   int   commands_sent = 0;

   fade_frame_scoreboard board;

   led_panel_fade_frame_sender dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // entry_index, green, red, blue, white, zero pad
      .req_tuser  (req_tuser),   // func
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // color_byte, module_number, led_number
      .rsp_tuser  (rsp_tuser),   // channel
      .rsp_tlast  (rsp_tlast)    // last_of_frame
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Byte channel: check every transaction, then pick the next ready level.
   // A long hold takes priority over the random idling.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         board.check_byte(rsp_tdata[7:0], rsp_tuser, rsp_tdata[12:8],
                          rsp_tdata[15:13], rsp_tlast);
      end
      if (long_hold_request && !hold_taken) begin
         hold_left  = LONG_HOLD_CYCLES;
         hold_taken = 1'b1;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Offer one command, idling first at the current rate; return at the edge
   // where the transaction is accepted, with tvalid still high.
   task automatic send_command(input logic [1:0] code,
                               input logic [ENTRY_INDEX_W-1:0] index,
                               input logic [ENTRY_W-1:0] entry);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= code;
      req_tdata  <= {1'b0, entry, index};
      do @(posedge clock); while (!req_tready);
      board.note_command(code, index, entry);
      commands_sent++;
   endtask

   // Ready with random payload bits, which the block must ignore
   task automatic send_ready();
      send_command(lpffs_pkg::FUNC_READY, ENTRY_INDEX_W'($urandom_range(127)), $urandom());
   endtask

   // Mostly readies to push frames forward, with ticks, writes and noise
   task automatic send_random_command();
      int pick;
      pick = $urandom_range(99);
      if (pick < 80) begin
         send_ready();
      end else if (pick < 88) begin
         send_command(lpffs_pkg::FUNC_TICK, ENTRY_INDEX_W'($urandom_range(127)),
                      $urandom());
      end else if (pick < 97) begin
         send_command(lpffs_pkg::FUNC_WRITE, ENTRY_INDEX_W'($urandom_range(127)),
                      $urandom());
      end else begin
         send_command(FUNC_UNUSED, ENTRY_INDEX_W'($urandom_range(127)), $urandom());
      end
   endtask

   // Hold the sender idle until every owed byte has been seen
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   initial begin
      logic [ENTRY_W-1:0] fill;
      int guard;

      board = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Fill every table entry before any frame can read it; pin the
      // extremes at the two ends of the table.
      for (int i = 0; i < GRADIENT_ENTRIES; i++) begin
         if (i == 0) fill = '0;
         else if (i == GRADIENT_ENTRIES - 1) fill = '1;
         else fill = $urandom();
         send_command(lpffs_pkg::FUNC_WRITE, ENTRY_INDEX_W'(i), fill);
      end

      // Directed: unused code while idle, tick opening a frame, tick and
      // unused code inside a frame, then rewrite entries the frame is using.
      send_command(FUNC_UNUSED, '1, '1);
      send_command(lpffs_pkg::FUNC_TICK, '0, '0);
      send_command(lpffs_pkg::FUNC_TICK, '1, '1);
      send_command(FUNC_UNUSED, '0, '0);
      repeat (3) send_ready();
      send_command(lpffs_pkg::FUNC_WRITE, ENTRY_INDEX_W'(1), 32'h0000_0000);
      send_command(lpffs_pkg::FUNC_WRITE, ENTRY_INDEX_W'(2), 32'hFFFF_FFFF);
      repeat (6) send_ready();

      // Pause the sender until the output side has caught up
      wait_drained();

      // Stall the byte channel for a long stretch while readies keep coming,
      // so the pipeline fills and the command channel backs up.
      long_hold_request <= 1'b1;
      repeat (12) send_ready();

      // Random traffic under the three idling mixes
      repeat (280) send_random_command();
      send_idle_pct = 78;
      recv_idle_pct = 16;
      repeat (280) send_random_command();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (280) send_random_command();

      // Stop offering, drain, and let the pipeline settle
      req_tvalid <= 1'b0;
      guard = 0;
      while (board.pending() != 0 && guard < DRAIN_CAP) begin
         @(posedge clock);
         guard++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.pending() != 0) begin
         board.errors++;
         $display("%0t: bytes never delivered: expected %0d more actual 0",
                  $time, board.pending());
      end

      $display("Covered %0d commands, %0d bytes checked, %0d frames closed.",
               commands_sent, board.bytes_checked, board.frames_closed);
      $display("Table writes, ticks inside and outside frames, stalls on both sides;"
               , " window offset peaked at %0d.", board.offset_peak);
      if (board.errors == 0) begin
         $display("led_panel_fade_frame_sender_test: clean");
      end else begin
         $display("led_panel_fade_frame_sender_test: errors");
      end
      $finish;
   end

   // Hard stop well beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("led_panel_fade_frame_sender_test: errors");
      $finish;
   end

endmodule

### filelist.f
hw/rtl/lpffs_pkg.sv
hw/rtl/lpffs_ram.sv
hw/rtl/led_panel_fade_frame_sender.sv
bench/led_panel_fade_frame_sender_test.sv
